/* rtl/dltc_pkg.sv */
// ----------------------------------------------------------------------------
// dltc_pkg
// Shared types, codes and helpers for the diff line token codec.
// ----------------------------------------------------------------------------
package dltc_pkg;

  localparam int JOB_BYTES         = 5;
  localparam int JOB_CNT_W         = 3;
  localparam int DLTC_QUEUE_DEPTH  = 4;

  typedef enum logic [2:0] {
    MODE_W_ENC = 3'd0,
    MODE_C_ENC = 3'd1,
    MODE_X_ENC = 3'd2,
    MODE_B_ENC = 3'd3,
    MODE_W_DEC = 3'd4,
    MODE_C_DEC = 3'd5,
    MODE_X_DEC = 3'd6,
    MODE_B_DEC = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_CMD  = 2'd1,
    ERR_NL   = 2'd2,
    ERR_HEX  = 2'd3
  } err_t;

  // Line phase; the decoders read the same codes as: expect command /
  // turn spaces into newlines / copy to end of line (W, C), and
  // skip blanks / one digit held / discard rest of line (X, B).
  typedef enum logic [1:0] {
    PH_START   = 2'd0,
    PH_NEWLINE = 2'd1,
    PH_SPACE   = 2'd2,
    PH_WORD    = 2'd3
  } phase_t;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Up to five output bytes caused by one input item
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [JOB_CNT_W-1:0]      count;
    err_t                      err;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) begin
      return 8'h30 + {4'd0, v};
    end
    return 8'h37 + {4'd0, v};
  endfunction

endpackage

/* rtl/dltc_in_if.sv */
// ----------------------------------------------------------------------------
// dltc_in_if
// Input channel: one stream byte or an end-of-stream mark per transaction.
// ----------------------------------------------------------------------------
interface dltc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

/* rtl/dltc_out_if.sv */
// ----------------------------------------------------------------------------
// dltc_out_if
// Output channel: one result byte with its last and error flags.
// ----------------------------------------------------------------------------
interface dltc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic [1:0] error;

  modport source (output valid, output out_byte, output last, output error, input ready);
  modport sink   (input valid, input out_byte, input last, input error, output ready);
endinterface

/* rtl/dltc_front.sv */
// ----------------------------------------------------------------------------
// dltc_front
// Takes input transactions, updates the line state and builds at most one
// job of output bytes per item.
// ----------------------------------------------------------------------------
module dltc_front
  import dltc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  dltc_in_if.sink     in_ch,
  input  logic        q_full,
  output logic        push,
  output job_t        push_job
);

  mode_t      mode;
  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] first_digit;
  logic [3:0] first_digit_next;
  logic       halted;
  logic       halted_next;

  logic       accept;
  logic [7:0] b;
  logic       eoi;
  logic       b_ws;
  logic       b_lf;
  logic [4:0] hv;   // {valid, value}

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
    return 5'd0;
  endfunction

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.in_byte;
  assign eoi         = in_ch.end_of_input;
  assign b_lf        = (b == CH_LF);
  assign b_ws        = (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
  assign hv          = hex_val(b);

  // Next state
  always_comb begin
    phase_next       = phase;
    first_digit_next = first_digit;
    halted_next      = halted;
    if (accept && !halted) begin
      if (eoi) begin
        phase_next       = PH_START;
        first_digit_next = 4'd0;
      end else begin
        case (mode)
          MODE_W_ENC, MODE_C_ENC: begin
            if (b_lf) phase_next = PH_NEWLINE;
            else if (b_ws) phase_next = PH_SPACE;
            else phase_next = (mode == MODE_C_ENC) ? PH_START : PH_WORD;
          end
          MODE_W_DEC, MODE_C_DEC: begin
            if (phase == PH_START) begin
              if (b == CH_COLON) phase_next = PH_SPACE;
              else if (b == CH_N) phase_next = PH_NEWLINE;
              else halted_next = 1'b1;
            end else if (phase == PH_NEWLINE) begin
              if (b_lf) phase_next = PH_START;
              else if (b != CH_SPACE) halted_next = 1'b1;
            end else begin
              if (b_lf) phase_next = PH_START;
            end
          end
          MODE_X_DEC, MODE_B_DEC: begin
            if (phase == PH_START) begin
              if (hv[4]) begin
                first_digit_next = hv[3:0];
                phase_next       = PH_NEWLINE;
              end else if (!b_ws) begin
                halted_next = 1'b1;
              end
            end else if (phase == PH_NEWLINE) begin
              first_digit_next = 4'd0;
              if (hv[4]) phase_next = PH_SPACE;
              else phase_next = b_lf ? PH_START : PH_SPACE;
            end else begin
              if (b_lf) phase_next = PH_START;
            end
          end
          default: ;  // hex dump modes keep no state
        endcase
      end
    end
  end

  // Job contents
  always_comb begin
    logic [JOB_CNT_W-1:0] n;
    err_t                 e;
    n        = '0;
    e        = ERR_NONE;
    push_job = '0;
    if (eoi) begin
      if ((mode == MODE_X_DEC || mode == MODE_B_DEC) && phase == PH_NEWLINE) begin
        push_job.bytes[n] = {4'd0, first_digit}; n = n + 1'b1;
      end
    end else begin
      case (mode)
        MODE_W_ENC, MODE_C_ENC: begin
          if (b_lf) begin
            if (phase == PH_NEWLINE) begin
              push_job.bytes[n] = CH_SPACE; n = n + 1'b1;
            end else begin
              if (phase != PH_START) begin
                push_job.bytes[n] = CH_LF; n = n + 1'b1;
              end
              push_job.bytes[n] = CH_N; n = n + 1'b1;
            end
          end else if (b_ws) begin
            if (phase == PH_NEWLINE) begin
              push_job.bytes[n] = CH_LF; n = n + 1'b1;
            end
            if (phase == PH_START || phase == PH_NEWLINE) begin
              push_job.bytes[n] = CH_COLON; n = n + 1'b1;
            end
            push_job.bytes[n] = b; n = n + 1'b1;
          end else begin
            if (phase == PH_NEWLINE || phase == PH_SPACE) begin
              push_job.bytes[n] = CH_LF; n = n + 1'b1;
            end
            if (phase != PH_WORD) begin
              push_job.bytes[n] = CH_COLON; n = n + 1'b1;
            end
            push_job.bytes[n] = b; n = n + 1'b1;
            if (mode == MODE_C_ENC) begin
              push_job.bytes[n] = CH_LF; n = n + 1'b1;
            end
          end
        end
        MODE_X_ENC, MODE_B_ENC: begin
          push_job.bytes[0] = hex_char(b[7:4]);
          push_job.bytes[1] = hex_char(b[3:0]);
          n = 3'd2;
          if (mode == MODE_X_ENC && b != CH_SPACE) begin
            push_job.bytes[2] = CH_SPACE;
            push_job.bytes[3] = (b > CH_SPACE && b < CH_DEL) ? b : CH_DOT;
            n = 3'd4;
          end
          push_job.bytes[n] = CH_LF; n = n + 1'b1;
        end
        MODE_W_DEC, MODE_C_DEC: begin
          if (phase == PH_START) begin
            if (b == CH_N) begin
              push_job.bytes[n] = CH_LF; n = n + 1'b1;
            end else if (b != CH_COLON) begin
              e = ERR_CMD;
            end
          end else if (phase == PH_NEWLINE) begin
            if (b == CH_SPACE) begin
              push_job.bytes[n] = CH_LF; n = n + 1'b1;
            end else if (!b_lf) begin
              e = ERR_NL;
            end
          end else if (!b_lf) begin
            push_job.bytes[n] = b; n = n + 1'b1;
          end
        end
        MODE_X_DEC, MODE_B_DEC: begin
          if (phase == PH_START) begin
            if (!hv[4] && !b_ws) e = ERR_HEX;
          end else if (phase == PH_NEWLINE) begin
            push_job.bytes[n] = hv[4] ? {first_digit, hv[3:0]} : {4'd0, first_digit};
            n = n + 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (e != ERR_NONE) begin
      push_job.bytes = '0;
      n              = 3'd1;
    end
    push_job.count = n;
    push_job.err   = e;
    push           = accept && !halted && (n != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_W_ENC;
      phase       <= PH_START;
      first_digit <= 4'd0;
      halted      <= 1'b0;
    end else begin
      if (cfg_wr_en) mode <= mode_t'(cfg_wr_data);
      phase       <= phase_next;
      first_digit <= first_digit_next;
      halted      <= halted_next;
    end
  end

endmodule

/* rtl/dltc_queue.sv */
// ----------------------------------------------------------------------------
// dltc_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module dltc_queue
  import dltc_pkg::*;
#(
  parameter int DEPTH = DLTC_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign pop_job = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/dltc_back.sv */
// ----------------------------------------------------------------------------
// dltc_back
// Serialises each job into output transactions, one byte per cycle while
// out_ch is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module dltc_back
  import dltc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  job_t        q_job,
  output logic        pop,
  dltc_out_if.source  out_ch
);

  job_t                 work;
  logic                 work_valid;
  logic [JOB_CNT_W-1:0] idx;
  logic                 at_end;
  logic                 out_load;
  logic                 work_done;

  assign at_end    = (idx == work.count - 1'b1);
  assign out_load  = work_valid && (!out_ch.valid || out_ch.ready);
  assign work_done = out_load && at_end;
  assign pop       = !q_empty && (!work_valid || work_done);

  always_ff @(posedge clk) begin
    if (pop) work <= q_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      idx        <= '0;
    end else if (pop) begin
      work_valid <= 1'b1;
      idx        <= '0;
    end else if (work_done) begin
      work_valid <= 1'b0;
    end else if (out_load) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.out_byte <= work.bytes[idx];
      out_ch.last     <= at_end;
      out_ch.error    <= work.err;
    end
  end

endmodule

/* rtl/diff_line_token_codec.sv */
// ----------------------------------------------------------------------------
// diff_line_token_codec
// Byte-stream codec that splits text into diff-friendly lines, dumps bytes
// as hex, and undoes both; errors halt the block until reset.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload                         Transaction rule
//  -------  ---------  ------------------------------  -------------------------
//  in_ch    sink       in_byte[7:0], end_of_input      valid & ready at clk edge
//  out_ch   source     out_byte[7:0], last, error[1:0] valid & ready at clk edge
//  cfg      write      cfg_wr_en, cfg_wr_data[2:0]     cfg_wr_en at clk edge
//
//  An input transaction is taken every cycle while the job queue has room;
//  the front decides all of an item's output bytes in that same cycle.
//  The back end sends one output byte per cycle while out_ch is ready; an
//  item has 0 to 5 result bytes (5 for any byte other than a space in mode
//  x), while in_ch takes at most one item per cycle.
//  A result passes through the queue, the work register and the output
//  register before it reaches out_ch. A stalled out_ch fills the queue
//  (QUEUE_DEPTH jobs), then in_ch.ready drops. Reset is synchronous: mode w,
//  line state cleared, queue and output stage empty.
//
module diff_line_token_codec
  import dltc_pkg::*;
#(
  parameter int QUEUE_DEPTH = DLTC_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  dltc_in_if.sink     in_ch,
  dltc_out_if.source  out_ch
);

  // Front to queue
  logic push;
  job_t push_job;
  logic q_full;

  // Queue to back end
  logic q_pop;
  job_t q_job;
  logic q_empty;

  // Classify each item and build its job; hold the mode register here
  dltc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  // Decouple the two sides so that each may stall on its own
  dltc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_job),
    .empty    (q_empty)
  );

  // Drain jobs byte by byte into the output register
  dltc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_job   (q_job),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

  // Never write into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("job pushed into a full queue");

  // Never take a job from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("job popped from an empty queue");

  // An error result stands alone: zero byte and the last flag
  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.error != ERR_NONE) |-> (out_ch.last && out_ch.out_byte == 8'd0))
    else $error("error result without last or with a non-zero byte");

endmodule

/* test/tb_diff_line_token_codec.sv */
// ----------------------------------------------------------------------------
// tb_diff_line_token_codec
// Self-checking bench for the diff line token codec. A behavioural codec
// model predicts the result bytes of every accepted input transaction. A
// monitor checks each output transaction against the oldest prediction. The
// stimulus starts with a short directed pass. Random phases follow in every
// mode, with both channels idling in several profiles. A receiver hold-off
// fills the block. The run ends on one deliberate error that halts the block.
// ----------------------------------------------------------------------------
module tb_diff_line_token_codec;
  import dltc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int PHASE_ITEMS    = 20;
  localparam int SHOW_LIMIT     = 10;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // Codec state as the model sees it; phase codes are read per mode
  typedef struct packed {
    mode_t      mode;
    phase_t     phase;
    logic [3:0] held;
    logic       halted;
  } codec_state_t;

  // Everything one input item causes: next state plus up to five bytes
  typedef struct packed {
    codec_state_t    nxt;
    logic [4:0][7:0] data;
    logic [2:0]      count;
    err_t            err;
  } step_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
  } stream_item_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    err_t       err;
  } out_byte_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  logic [2:0] cfg_wr_data;

  dltc_in_if  in_ch();
  dltc_out_if out_ch();

  diff_line_token_codec uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Stream bytes waiting for the driver, and result bytes still owed by the
  // block in the order they must appear
  stream_item_t stream_q[$];
  out_byte_t    owed_bytes[$];

  codec_state_t gen_st;        // state as seen by the stimulus generator
  codec_state_t model_st;      // state as seen by the checker
  int           idle_pct;
  int           stall_pct;
  int           holdoff_asks;
  int           mismatch_count;
  int           fed_count;
  int           taken_count;
  bit           in_took;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Codec model
  // --------------------------------------------------------------------------

  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  // Bit 4 set means the byte is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    if (b >= "0" && b <= "9") return {1'b0, b[3:0]};
    if (b >= "A" && b <= "F") return {1'b0, 4'(b - 8'h37)};
    if (b >= "a" && b <= "f") return {1'b0, 4'(b - 8'h57)};
    return 5'h10;
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    return (v < 4'd10) ? {4'h3, v} : 8'("A") + 8'(v) - 8'd10;
  endfunction

  // Append one byte; anything beyond five is dropped
  function automatic void put_byte(inout step_t r, input logic [7:0] x);
    if (r.count < 3'd5) begin
      r.data[r.count] = x;
      r.count = r.count + 3'd1;
    end
  endfunction

  // An error replaces any output with a single zero byte and halts the codec
  function automatic void halt_with(inout step_t r, input err_t code);
    r.data       = '0;
    r.count      = 3'd1;
    r.err        = code;
    r.nxt.halted = 1'b1;
  endfunction

  function automatic step_t codec_step(input codec_state_t st, input logic [7:0] b,
                                       input logic eoi);
    step_t      r;
    logic [4:0] hv;
    r.nxt   = st;
    r.data  = '0;
    r.count = '0;
    r.err   = ERR_NONE;
    hv      = hex_value(b);
    if (st.halted) return r;

    // End of stream: flush a held hex digit, then return to line start
    if (eoi) begin
      if ((st.mode == MODE_X_DEC || st.mode == MODE_B_DEC) && st.phase == PH_NEWLINE)
        put_byte(r, {4'd0, st.held});
      r.nxt.phase = PH_START;
      r.nxt.held  = '0;
      return r;
    end

    case (st.mode)
      MODE_W_ENC, MODE_C_ENC: begin
        if (b == CH_LF) begin
          // a newline opens an 'n' line; repeats add a space to it
          if (st.phase == PH_NEWLINE) begin
            put_byte(r, CH_SPACE);
          end else begin
            if (st.phase != PH_START) put_byte(r, CH_LF);
            put_byte(r, CH_N);
            r.nxt.phase = PH_NEWLINE;
          end
        end else if (is_blank(b)) begin
          if (st.phase == PH_NEWLINE) put_byte(r, CH_LF);
          if (st.phase == PH_START || st.phase == PH_NEWLINE) put_byte(r, CH_COLON);
          r.nxt.phase = PH_SPACE;
          put_byte(r, b);
        end else begin
          if (st.phase == PH_NEWLINE || st.phase == PH_SPACE) put_byte(r, CH_LF);
          if (st.phase != PH_WORD) put_byte(r, CH_COLON);
          r.nxt.phase = PH_WORD;
          put_byte(r, b);
          // mode c closes the line after every word byte
          if (st.mode == MODE_C_ENC) begin
            put_byte(r, CH_LF);
            r.nxt.phase = PH_START;
          end
        end
      end
      MODE_X_ENC, MODE_B_ENC: begin
        put_byte(r, nibble_char(b[7:4]));
        put_byte(r, nibble_char(b[3:0]));
        if (st.mode == MODE_X_ENC && b != CH_SPACE) begin
          put_byte(r, CH_SPACE);
          put_byte(r, (b > CH_SPACE && b < CH_DEL) ? b : CH_DOT);
        end
        put_byte(r, CH_LF);
      end
      MODE_W_DEC, MODE_C_DEC: begin
        if (st.phase == PH_START) begin
          if (b == CH_COLON) begin
            r.nxt.phase = PH_SPACE;
          end else if (b == CH_N) begin
            r.nxt.phase = PH_NEWLINE;
            put_byte(r, CH_LF);
          end else begin
            halt_with(r, ERR_CMD);
          end
        end else if (st.phase == PH_NEWLINE) begin
          if (b == CH_SPACE) put_byte(r, CH_LF);
          else if (b == CH_LF) r.nxt.phase = PH_START;
          else halt_with(r, ERR_NL);
        end else if (b == CH_LF) begin
          // word phase left over from an encoder behaves as a copy line
          r.nxt.phase = PH_START;
        end else begin
          put_byte(r, b);
        end
      end
      default: begin
        // hex readers
        if (st.phase == PH_START) begin
          if (!hv[4]) begin
            r.nxt.held  = hv[3:0];
            r.nxt.phase = PH_NEWLINE;
          end else if (!is_blank(b)) begin
            halt_with(r, ERR_HEX);
          end
        end else if (st.phase == PH_NEWLINE) begin
          if (!hv[4]) begin
            put_byte(r, {st.held, hv[3:0]});
            r.nxt.phase = PH_SPACE;
          end else begin
            put_byte(r, {4'd0, st.held});
            r.nxt.phase = (b == CH_LF) ? PH_START : PH_SPACE;
          end
          r.nxt.held = '0;
        end else if (b == CH_LF) begin
          r.nxt.phase = PH_START;
        end
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present the next stream byte at the falling edge; hold it until
  // the transaction completes
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_stream
    stream_item_t item;
    if (in_ch.valid && !in_took) begin
      // hold the current transaction
    end else if (stream_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
      item = stream_q.pop_front();
      in_ch.valid        <= 1'b1;
      in_ch.in_byte      <= item.data;
      in_ch.end_of_input <= item.eoi;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin : drive_ready
    int holdoff_seen;
    int holdoff_left;
    if (holdoff_asks != holdoff_seen) begin
      holdoff_seen = holdoff_asks;
      holdoff_left = HOLDOFF_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left = holdoff_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each input transaction, check each output transaction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    step_t     s;
    out_byte_t exp_b;
    in_took <= in_ch.valid && in_ch.ready;
    if (rst) begin
      model_st = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken_count++;
        s        = codec_step(model_st, in_ch.in_byte, in_ch.end_of_input);
        model_st = s.nxt;
        for (int i = 0; i < int'(s.count); i++)
          owed_bytes.push_back('{data: s.data[i], last: (i == int'(s.count) - 1),
                                 err: s.err});
      end
      if (out_ch.valid && out_ch.ready) begin
        if (owed_bytes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_LIMIT)
            $display("%0t: unexpected output byte %h last %b error %0d", $realtime,
                     out_ch.out_byte, out_ch.last, out_ch.error);
        end else begin
          exp_b = owed_bytes.pop_front();
          if (out_ch.out_byte !== exp_b.data || out_ch.last !== exp_b.last ||
              out_ch.error !== exp_b.err) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_LIMIT)
              $display("%0t: expected byte %h last %b error %0d, got byte %h last %b error %0d",
                       $realtime, exp_b.data, exp_b.last, exp_b.err,
                       out_ch.out_byte, out_ch.last, out_ch.error);
          end
        end
      end
      if (cfg_wr_en) model_st.mode = mode_t'(cfg_wr_data);
    end
  end

  // Watchdog: too long without any transaction or register write ends the run
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || cfg_wr_en || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet = 0;
    else
      quiet = quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Queue one stream byte. Unless an error is wanted, swap a byte that would
  // halt the codec for a harmless one, judged on the generator's own state.
  task automatic feed(input logic [7:0] b, input logic eoi, input bit may_fail);
    step_t      r;
    logic [7:0] v;
    v = b;
    r = codec_step(gen_st, v, eoi);
    if (r.err != ERR_NONE && !may_fail) begin
      v = (gen_st.phase == PH_START &&
           (gen_st.mode == MODE_W_DEC || gen_st.mode == MODE_C_DEC)) ? CH_COLON : CH_SPACE;
      r = codec_step(gen_st, v, eoi);
    end
    gen_st = r.nxt;
    stream_q.push_back('{data: v, eoi: eoi});
    fed_count++;
  endtask

  function automatic logic [7:0] blank_byte();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
  endfunction

  function automatic logic [7:0] hex_digit_char();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    if (v < 4'd10) return {4'h3, v};
    return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(v) - 8'd10;
  endfunction

  // Wait until every queued item has been taken by the block and every owed
  // byte has arrived, then let the pipeline settle, since an item may cause
  // no result at all
  task automatic wait_idle();
    while (taken_count != fed_count || owed_bytes.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    gen_st.mode = m;
    @(posedge clk);
  endtask

  task automatic set_idling(input int profile);
    case (profile)
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 80; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 80; end
      default: begin idle_pct = 15; stall_pct = 15; end
    endcase
  endtask

  // One short random sequence suited to the mode. Decoders mostly get
  // well-formed lines so they get past line start; the rest is noise.
  task automatic add_burst(input mode_t m);
    int         k;
    int         len;
    logic [7:0] b;
    k = $urandom_range(0, 99);
    case (m)
      MODE_W_ENC, MODE_C_ENC: begin
        if (k < 4)       feed(8'($urandom), 1'b1, 1'b0);
        else if (k < 18) feed(CH_LF, 1'b0, 1'b0);
        else if (k < 32) feed(blank_byte(), 1'b0, 1'b0);
        else if (k < 82) feed(8'($urandom_range(8'h21, 8'h7E)), 1'b0, 1'b0);
        else             feed(8'($urandom), 1'b0, 1'b0);
      end
      MODE_X_ENC, MODE_B_ENC: begin
        feed(8'($urandom), k < 4, 1'b0);
      end
      MODE_W_DEC, MODE_C_DEC: begin
        if (k < 50) begin
          // copy line: ':' text newline
          feed(CH_COLON, 1'b0, 1'b0);
          len = $urandom_range(0, 6);
          repeat (len) begin
            b = 8'($urandom);
            if (b == CH_LF) b = CH_N;
            feed(b, 1'b0, 1'b0);
          end
          feed(CH_LF, 1'b0, 1'b0);
        end else if (k < 80) begin
          // newline run: 'n' spaces newline
          feed(CH_N, 1'b0, 1'b0);
          len = $urandom_range(0, 3);
          repeat (len) feed(CH_SPACE, 1'b0, 1'b0);
          feed(CH_LF, 1'b0, 1'b0);
        end else if (k < 88) begin
          feed(8'($urandom), 1'b1, 1'b0);
        end else begin
          feed(8'($urandom), 1'b0, 1'b0);
        end
      end
      default: begin
        if (k < 75) begin
          // value line: blanks, one or two digits, junk, newline
          len = $urandom_range(0, 2);
          repeat (len) feed(blank_byte(), 1'b0, 1'b0);
          feed(hex_digit_char(), 1'b0, 1'b0);
          if ($urandom_range(0, 1)) feed(hex_digit_char(), 1'b0, 1'b0);
          len = $urandom_range(0, 3);
          repeat (len) begin
            b = 8'($urandom);
            if (b == CH_LF) b = 8'h2D;
            feed(b, 1'b0, 1'b0);
          end
          feed(CH_LF, 1'b0, 1'b0);
        end else if (k < 85) begin
          // single digit cut off by end of stream
          feed(CH_LF, 1'b0, 1'b0);
          feed(hex_digit_char(), 1'b0, 1'b0);
          feed(8'($urandom), 1'b1, 1'b0);
        end else begin
          feed(8'($urandom), 1'b0, 1'b0);
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    mode_t modes[12];
    err_t  fault;
    int    target;

    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = '0;
    in_ch.end_of_input = 1'b0;
    out_ch.ready       = 1'b0;
    idle_pct           = 0;
    stall_pct          = 0;
    holdoff_asks       = 0;
    mismatch_count     = 0;
    fed_count          = 0;
    taken_count        = 0;
    gen_st             = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass: field extremes, all modes but the c/b decoders, newline runs,
    // a word left open across a mode change, and a digit cut off by end of stream
    set_idling(0);
    write_mode(MODE_W_ENC);
    feed(8'h00, 1'b0, 1'b0);
    feed(8'hFF, 1'b0, 1'b0);
    feed(CH_LF, 1'b0, 1'b0);
    feed(CH_LF, 1'b0, 1'b0);
    feed(CH_SPACE, 1'b0, 1'b0);
    feed("a", 1'b0, 1'b0);
    feed(8'hFF, 1'b1, 1'b0);
    feed("Q", 1'b0, 1'b0);
    wait_idle();
    // still in a word line: the line decoder must treat it as a copy line
    write_mode(MODE_W_DEC);
    feed("b", 1'b0, 1'b0);
    feed(CH_LF, 1'b0, 1'b0);
    feed(CH_N, 1'b0, 1'b0);
    feed(CH_SPACE, 1'b0, 1'b0);
    feed(CH_LF, 1'b0, 1'b0);
    wait_idle();
    write_mode(MODE_C_ENC);
    feed("a", 1'b0, 1'b0);
    feed(CH_SPACE, 1'b0, 1'b0);
    wait_idle();
    write_mode(MODE_X_ENC);
    feed(CH_SPACE, 1'b0, 1'b0);
    feed(CH_DEL, 1'b0, 1'b0);
    feed("A", 1'b0, 1'b0);
    wait_idle();
    write_mode(MODE_B_ENC);
    feed(8'hA5, 1'b0, 1'b0);
    wait_idle();
    write_mode(MODE_X_DEC);
    feed(CH_LF, 1'b0, 1'b0);
    feed("a", 1'b0, 1'b0);
    feed("F", 1'b0, 1'b0);
    feed(CH_LF, 1'b0, 1'b0);
    feed("7", 1'b0, 1'b0);
    feed(8'h00, 1'b1, 1'b0);
    wait_idle();

    // Random phases; no end of stream is forced between them, so the state
    // of one mode carries over into the next
    modes = '{MODE_W_ENC, MODE_W_DEC, MODE_C_ENC, MODE_C_DEC, MODE_X_ENC, MODE_X_DEC,
              MODE_B_ENC, MODE_B_DEC, MODE_W_ENC, MODE_X_DEC, MODE_C_ENC, MODE_B_DEC};
    foreach (modes[i]) begin
      set_idling(i % 4);
      write_mode(modes[i]);
      target = fed_count + PHASE_ITEMS;
      if (i == 5) begin
        // sender pauses mid-phase until every owed byte has come back
        while (fed_count < target - PHASE_ITEMS / 2) add_burst(modes[i]);
        wait_idle();
      end
      while (fed_count < target) add_burst(modes[i]);
      wait_idle();

      // After the hex dump phase: hold the receiver off while the sender keeps
      // offering printable bytes, so the job queue fills and input stalls
      if (modes[i] == MODE_X_ENC) begin
        set_idling(0);
        repeat (24) feed(8'($urandom_range(8'h21, 8'h7E)), 1'b0, 1'b0);
        holdoff_asks++;
        wait_idle();
      end
    end

    // Finish on one error: the block must report it and then stay silent
    set_idling(3);
    fault = err_t'($urandom_range(1, 3));
    case (fault)
      ERR_CMD: begin
        write_mode(MODE_W_DEC);
        feed(8'($urandom), 1'b1, 1'b0);
        feed("q", 1'b0, 1'b1);
      end
      ERR_NL: begin
        write_mode(MODE_C_DEC);
        feed(8'($urandom), 1'b1, 1'b0);
        feed(CH_N, 1'b0, 1'b0);
        feed("x", 1'b0, 1'b1);
      end
      default: begin
        write_mode(MODE_X_DEC);
        feed(8'($urandom), 1'b1, 1'b0);
        feed(CH_SPACE, 1'b0, 1'b0);
        feed("g", 1'b0, 1'b1);
      end
    endcase
    feed("a", 1'b0, 1'b0);
    feed(8'h00, 1'b1, 1'b0);
    feed(CH_COLON, 1'b0, 1'b0);
    wait_idle();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
